/* src/dr96_pkg.sv */
// ----------------------------------------------------------------------------
// dr96_pkg
// Shared types and constants for the decimal round-to-integer pipeline.
// ----------------------------------------------------------------------------
package dr96_pkg;

    localparam int MAX_SCALE  = 28;
    localparam int NUM_LIMBS  = 3;
    localparam int NUM_STAGES = MAX_SCALE * NUM_LIMBS;

    localparam logic [31:0] SIGN_MASK     = 32'h8000_0000;
    localparam logic [31:0] SCALE_MASK    = 32'h00FF_0000;
    localparam logic [31:0] RESERVED_MASK = ~(SIGN_MASK | SCALE_MASK);

    // 2^32 = 10 * LIMB_QUOT + LIMB_REM
    localparam logic [31:0] LIMB_QUOT = 32'd429496729;
    localparam logic [3:0]  LIMB_REM  = 4'd6;
    // ceil(2^37 / 10), exact for dividends below 2^34
    localparam logic [33:0] RECIP10   = 34'd13743895348;
    localparam int          RECIP_SH  = 37;

    typedef enum logic [1:0] {
        OP_TRUNC  = 2'd0,
        OP_FLOOR  = 2'd1,
        OP_ROUND  = 2'd2,
        OP_NEGATE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] mant_low;
        logic [31:0] mant_mid;
        logic [31:0] mant_high;
        logic [31:0] flag_word;
    } in_req_t;

    typedef struct packed {
        logic [31:0] res_low;
        logic [31:0] res_mid;
        logic [31:0] res_high;
        logic [31:0] res_flags;
        logic        bad_input;
    } out_req_t;

    // Working state that travels down the pipe
    typedef struct packed {
        op_t                      op;
        logic [2:0][31:0]         mant;
        logic [31:0]              flags;
        logic [4:0]               scale;
        logic                     err;
        logic [3:0]               rem;
        logic [3:0]               top;
        logic                     sticky;
    } pipe_t;

endpackage

/* src/dr96_limb_stage.sv */
// ----------------------------------------------------------------------------
// dr96_limb_stage
// One registered step of a divide by ten: a single 32-bit limb, carrying the
// running remainder from the limb above.
// ----------------------------------------------------------------------------
module dr96_limb_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic [1:0]     limb_idx,
    input  logic [4:0]     digit_idx,
    input  logic           in_valid,
    input  dr96_pkg::pipe_t in_data,
    output logic           out_valid,
    output dr96_pkg::pipe_t out_data
);
    import dr96_pkg::*;

    logic        valid_reg;
    pipe_t       data_reg;
    pipe_t       data_next;
    logic        active;
    logic [3:0]  r_in;
    logic [31:0] limb;
    logic [32:0] t_val;
    logic [66:0] prod;
    logic [29:0] q_low;
    logic [31:0] q_full;
    logic [32:0] rem_wide;

    // Divide (r * 2^32 + limb) by ten via t = 6r + limb
    always_comb begin
        active    = !in_data.err && (in_data.op != OP_NEGATE) && (digit_idx < in_data.scale);
        data_next = in_data;
        r_in      = (limb_idx == 2'd2) ? 4'd0 : in_data.rem;
        limb      = in_data.mant[limb_idx];
        t_val     = {1'b0, limb} + 33'(r_in) * 33'(LIMB_REM);
        prod      = 67'(t_val) * 67'(RECIP10);
        q_low     = prod[66:RECIP_SH];
        q_full    = 32'(r_in) * LIMB_QUOT + {2'b00, q_low};
        rem_wide  = t_val - {q_low, 3'b000} - {2'b00, q_low, 1'b0};
        if (active) begin
            if (limb_idx == 2'd2) begin
                data_next.sticky = in_data.sticky || (in_data.top != 4'd0);
            end
            data_next.mant[limb_idx] = q_full;
            data_next.rem            = rem_wide[3:0];
            if (limb_idx == 2'd0) begin
                data_next.top = rem_wide[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/dr96_finish.sv */
// ----------------------------------------------------------------------------
// dr96_finish
// Final increment for floor and round, sign handling and output register.
// ----------------------------------------------------------------------------
module dr96_finish (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  dr96_pkg::pipe_t in_data,
    output logic            out_valid,
    output dr96_pkg::out_req_t out_data
);
    import dr96_pkg::*;

    logic     valid_reg;
    out_req_t res_reg;
    out_req_t res_next;
    logic     inc;
    logic     neg;
    logic     above;
    logic     half;
    logic [95:0] mag;
    logic [95:0] mag_inc;

    always_comb begin
        neg     = in_data.flags[31];
        above   = (in_data.top > 4'd5) || (in_data.top == 4'd5 && in_data.sticky);
        half    = (in_data.top == 4'd5) && !in_data.sticky;
        mag     = {in_data.mant[2], in_data.mant[1], in_data.mant[0]};
        mag_inc = mag + 96'd1;
        case (in_data.op)
            OP_FLOOR: inc = neg && (in_data.top != 4'd0 || in_data.sticky);
            OP_ROUND: inc = above || (half && mag[0]);
            default:  inc = 1'b0;
        endcase
        res_next = '0;
        if (in_data.err) begin
            res_next.bad_input = 1'b1;
        end else begin
            {res_next.res_high, res_next.res_mid, res_next.res_low} = inc ? mag_inc : mag;
            if (in_data.op == OP_NEGATE) begin
                res_next.res_flags = in_data.flags ^ SIGN_MASK;
            end else begin
                res_next.res_flags = in_data.flags & SIGN_MASK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

/* src/decimal96_round_to_integer_unit.sv */
// ----------------------------------------------------------------------------
// decimal96_round_to_integer_unit
// Truncate, floor, round half to even or negate a 96-bit decimal value.
// ----------------------------------------------------------------------------
//  channel  ports                    direction  payload
//  s_       s_valid/s_ready/s_data   in         operation, mantissa, flags
//  m_       m_valid/m_ready/m_data   out        result mantissa, flags, error
//
//  The pipe holds 84 limb stages (28 digits x 3 limbs) between the check
//  and finish registers. One request enters per cycle when not stalled.
//  Each limb stage holds one 33x34 reciprocal multiply.
//  aresetn is synchronous and clears all valid bits.
//  When m_valid is high and m_ready low, the whole pipe holds.
// ----------------------------------------------------------------------------
module decimal96_round_to_integer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dr96_pkg::in_req_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dr96_pkg::out_req_t  m_data
);
    import dr96_pkg::*;

    logic  advance;
    logic  entry_valid_reg;
    pipe_t entry_reg;
    pipe_t entry_next;
    logic  stage_valid [NUM_STAGES+1];
    pipe_t stage_data  [NUM_STAGES+1];

    assign advance = m_ready || !m_valid;
    assign s_ready = advance;

    // Flag check and unpack
    always_comb begin
        entry_next.op     = op_t'(s_data.operation);
        entry_next.mant   = {s_data.mant_high, s_data.mant_mid, s_data.mant_low};
        entry_next.flags  = s_data.flag_word;
        entry_next.scale  = s_data.flag_word[20:16];
        entry_next.err    = ((s_data.flag_word & RESERVED_MASK) != 32'd0)
                         || (s_data.flag_word[23:16] > 8'(MAX_SCALE));
        entry_next.rem    = 4'd0;
        entry_next.top    = 4'd0;
        entry_next.sticky = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (advance) begin
            entry_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_reg <= entry_next;
        end
    end

    assign stage_valid[0] = entry_valid_reg;
    assign stage_data[0]  = entry_reg;

    // Limb stages, top limb first for each digit
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        dr96_limb_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .limb_idx  (2'(NUM_LIMBS - 1 - (g % NUM_LIMBS))),
            .digit_idx (5'(g / NUM_LIMBS)),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    dr96_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (stage_valid[NUM_STAGES]),
        .in_data   (stage_data[NUM_STAGES]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // An error result carries nothing else
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_input |->
            m_data.res_low == 32'd0 && m_data.res_mid == 32'd0 &&
            m_data.res_high == 32'd0 && m_data.res_flags == 32'd0)
        else $error("error result with nonzero fields");

    // Reserved flag bits never leave the block
    a_flags_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.res_flags & RESERVED_MASK) == 32'd0)
        else $error("reserved result flag bits set");

    // A held result freezes the whole pipe
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

/* test/decimal96_round_to_integer_unit_test.sv */
// ----------------------------------------------------------------------------
// decimal96_round_to_integer_unit_test
// Self-checking bench: directed corner requests then random decimal values,
// each result compared against a behavioural model of the rounding rules.
// ----------------------------------------------------------------------------
module decimal96_round_to_integer_unit_test;
    import dr96_pkg::*;

    localparam int N_RANDOM    = 1630;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 120;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_req_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_req_t   m_data;

    in_req_t    pending_reqs[$];
    out_req_t   expected_results[$];
    int         errors = 0;
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_bad = 0;
    int         idle_cnt = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         quiet = 1'b0;

    decimal96_round_to_integer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Behavioural model of one request
    function automatic out_req_t round_decimal(in_req_t r);
        out_req_t   res;
        logic [95:0] mag;
        logic [7:0]  sc;
        logic [3:0]  digit;
        logic        sticky;
        logic        bump;
        res = '0;
        mag = {r.mant_high, r.mant_mid, r.mant_low};
        sc = r.flag_word[23:16];
        digit = '0;
        sticky = 1'b0;
        bump = 1'b0;
        if ((r.flag_word & RESERVED_MASK) != 0 || sc > MAX_SCALE) begin
            res.bad_input = 1'b1;
            return res;
        end
        if (op_t'(r.operation) == OP_NEGATE) begin
            res.res_flags = r.flag_word ^ SIGN_MASK;
        end else begin
            for (int k = 0; k < sc; k++) begin
                if (digit != 0) sticky = 1'b1;
                digit = 4'(mag % 10);
                mag = mag / 10;
            end
            case (op_t'(r.operation))
                OP_FLOOR: bump = r.flag_word[31] && (digit != 0 || sticky);
                OP_ROUND: bump = digit > 5 || (digit == 5 && (sticky || mag[0]));
                default:  bump = 1'b0;
            endcase
            if (bump) mag = mag + 1;
            res.res_flags = r.flag_word & SIGN_MASK;
        end
        {res.res_high, res.res_mid, res.res_low} = mag;
        return res;
    endfunction

    function automatic logic [31:0] rand_flags(bit allow_bad);
        logic [31:0] f;
        f = {1'($urandom_range(0, 1)), 7'd0, 8'($urandom_range(0, MAX_SCALE)), 16'd0};
        if (allow_bad) begin
            case ($urandom_range(0, 2))
                0: f = f | ($urandom() & RESERVED_MASK);
                1: f[23:16] = 8'($urandom_range(MAX_SCALE + 1, 255));
                default: f = $urandom();
            endcase
        end
        return f;
    endfunction

    // Mantissa with random digit-sized magnitude so small scales still round
    function automatic logic [95:0] rand_mant();
        logic [95:0] m;
        m = {$urandom(), $urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: m = m >> $urandom_range(0, 95);
            1: m = 96'(5) * (96'(10) ** $urandom_range(0, 27)) + 96'($urandom_range(0, 3));
            default: ;
        endcase
        return m;
    endfunction

    task automatic add_req(logic [1:0] op, logic [95:0] m, logic [31:0] f);
        in_req_t r;
        r.operation = op;
        {r.mant_high, r.mant_mid, r.mant_low} = m;
        r.flag_word = f;
        pending_reqs.push_back(r);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(round_decimal(s_data));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 13);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    out_req_t e;
                    e = expected_results.pop_front();
                    if (e !== m_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, m_data);
                        errors++;
                    end
                    if (e.bad_input) n_bad++;
                    n_checked++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("%0t: no progress, %0d results outstanding", $time,
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [95:0] all_ones;
        all_ones = '1;
        // Directed corners
        add_req(OP_TRUNC,  all_ones, 32'h001C_0000);
        add_req(OP_FLOOR,  all_ones, 32'h801C_0000);
        add_req(OP_ROUND,  all_ones, 32'h001C_0000);
        add_req(OP_NEGATE, all_ones, 32'h801C_0000);
        add_req(OP_TRUNC,  all_ones, 32'h0000_0000);
        add_req(OP_ROUND,  96'd25,   32'h0001_0000); // half, even stays
        add_req(OP_ROUND,  96'd35,   32'h8001_0000); // half, odd goes up
        add_req(OP_ROUND,  96'd2501, 32'h0003_0000); // above half via sticky
        add_req(OP_ROUND,  96'd26,   32'h0001_0000);
        add_req(OP_FLOOR,  96'd21,   32'h8001_0000);
        add_req(OP_FLOOR,  96'd21,   32'h0001_0000);
        add_req(OP_FLOOR,  96'd1,    32'h801C_0000); // tiny negative
        add_req(OP_TRUNC,  96'd7,    32'h8001_0000); // negative zero
        add_req(OP_NEGATE, 96'd0,    32'h0000_0000);
        add_req(OP_TRUNC,  96'd5,    32'h001D_0000); // scale over limit
        add_req(OP_NEGATE, 96'd5,    32'h0000_0001); // reserved bit
        add_req(OP_ROUND,  96'd5,    32'hFFFF_FFFF);
        add_req(OP_FLOOR,  96'd0,    32'h7F00_0000);
        add_req(OP_ROUND,  96'd5,    32'h0001_0000);
        add_req(OP_ROUND,  96'd15,   32'h0001_0000);
        for (int i = 0; i < N_RANDOM; i++)
            add_req(2'($urandom_range(0, 3)), rand_mant(),
                    rand_flags($urandom_range(0, 9) == 0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // Final stretch runs without idling
        wait (pending_reqs.size() < 200);
        quiet = 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Requests sent %0d, results checked %0d, flagged invalid %0d",
                 n_sent, n_checked, n_bad);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
